>>> rtl/rcv_pkg.sv
`timescale 1ns / 1ps

package rcv_pkg;

   localparam logic [15:0] REC_MAGIC     = 16'h504B;
   localparam logic [7:0]  REC_VERSION   = 8'h01;
   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [15:0] CRC_POLY      = 16'h1021;
   localparam logic [7:0]  RESERVED_BITS = 8'hF0;
   localparam logic [3:0]  CRC_SPAN      = 4'd14;
   localparam logic [3:0]  LAST_BYTE     = 4'd15;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_MAGIC    = 3'd1,
      ST_VERSION  = 3'd2,
      ST_RESERVED = 3'd3,
      ST_CRC      = 3'd4
   } status_type;

   typedef struct packed {
      logic        record_valid;
      status_type  status;
      logic [3:0]  occupancy_mask;
      logic [31:0] entry_count;
      logic [31:0] exit_count;
      logic [15:0] sequence_res;
   } result_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

>>> rtl/rcv_record.sv
`timescale 1ns / 1ps

module rcv_record
   import rcv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] data_byte,
   input  logic       start_record,
   output logic       last,
   output result_type result
);

   logic [3:0]  byte_index_ff, byte_index_in;
   logic [15:0] crc_ff, crc_in;
   logic [1:0]  hdr_ff, hdr_in;
   logic [7:0]  magic_low_ff, magic_low_in;
   logic [7:0]  mask_ff, mask_in;
   logic [31:0] entry_ff, entry_in;
   logic [31:0] exit_ff, exit_in;
   logic [15:0] seq_ff, seq_in;
   logic [7:0]  crc_low_ff, crc_low_in;

   logic [3:0]  idx;
   logic [15:0] crc_base;
   logic [1:0]  hdr_base;
   logic [15:0] stored;
   status_type  status;
   logic        ok;

   always_comb begin
      idx      = start_record ? 4'd0 : byte_index_ff;
      crc_base = start_record ? CRC_INIT : crc_ff;
      hdr_base = start_record ? 2'd0 : hdr_ff;
      last     = (idx == LAST_BYTE);

      crc_in       = crc_base;
      hdr_in       = hdr_base;
      magic_low_in = magic_low_ff;
      mask_in      = mask_ff;
      entry_in     = entry_ff;
      exit_in      = exit_ff;
      seq_in       = seq_ff;
      crc_low_in   = crc_low_ff;

      if (idx < CRC_SPAN) begin
         crc_in = crc_byte(crc_base, data_byte);
      end

      if (idx == 4'd0) begin
         magic_low_in = data_byte;
      end else if (idx == 4'd1) begin
         if ({data_byte, magic_low_ff} != REC_MAGIC && hdr_base == 2'd0) begin
            hdr_in = ST_MAGIC[1:0];
         end
      end else if (idx == 4'd2) begin
         if (data_byte != REC_VERSION && hdr_base == 2'd0) begin
            hdr_in = ST_VERSION[1:0];
         end
      end else if (idx == 4'd3) begin
         if ((data_byte & RESERVED_BITS) != 8'h00 && hdr_base == 2'd0) begin
            hdr_in = ST_RESERVED[1:0];
         end
         mask_in = data_byte;
      end else if (idx inside {[4'd4:4'd7]}) begin
         entry_in = {data_byte, entry_ff[31:8]};
      end else if (idx inside {[4'd8:4'd11]}) begin
         exit_in = {data_byte, exit_ff[31:8]};
      end else if (idx inside {[4'd12:4'd13]}) begin
         seq_in = {data_byte, seq_ff[15:8]};
      end else if (idx == CRC_SPAN) begin
         crc_low_in = data_byte;
      end

      byte_index_in = idx + 4'd1;
      if (last) begin
         byte_index_in = 4'd0;
         crc_in        = CRC_INIT;
         hdr_in        = 2'd0;
      end

      stored = {data_byte, crc_low_ff};
      if (hdr_base != 2'd0) begin
         status = status_type'({1'b0, hdr_base});
      end else if (stored != crc_ff) begin
         status = ST_CRC;
      end else begin
         status = ST_OK;
      end
      ok = (status == ST_OK);

      result.record_valid   = ok;
      result.status         = status;
      result.occupancy_mask = ok ? mask_ff[3:0] : 4'd0;
      result.entry_count    = ok ? entry_ff : 32'd0;
      result.exit_count     = ok ? exit_ff : 32'd0;
      result.sequence_res   = ok ? seq_ff : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= 4'd0;
         crc_ff        <= CRC_INIT;
         hdr_ff        <= 2'd0;
      end else if (step) begin
         byte_index_ff <= byte_index_in;
         crc_ff        <= crc_in;
         hdr_ff        <= hdr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         magic_low_ff <= magic_low_in;
         mask_ff      <= mask_in;
         entry_ff     <= entry_in;
         exit_ff      <= exit_in;
         seq_ff       <= seq_in;
         crc_low_ff   <= crc_low_in;
      end
   end

endmodule

>>> rtl/rcv_out.sv
`timescale 1ns / 1ps

module rcv_out
   import rcv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type result,
   output logic       out_free,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp_data
);

   logic       rsp_valid_ff;
   result_type data_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (load && out_free) begin
         data_ff <= result;
      end
   end

`ifndef SYNTHESIS
   a_valid_matches_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (data_ff.record_valid == (data_ff.status == ST_OK)))
      else $error("record_valid disagrees with status");
   a_failed_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !data_ff.record_valid) |->
         (data_ff.occupancy_mask == 4'd0 && data_ff.entry_count == 32'd0 &&
          data_ff.exit_count == 32'd0 && data_ff.sequence_res == 16'd0))
      else $error("failed record carries nonzero fields");
   a_no_load_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(data_ff)))
      else $error("result register overwritten while stalled");
`endif

endmodule

>>> rtl/record_crc16_validator.sv
`timescale 1ns / 1ps
// Path: a byte item is accepted into the input register, and the result for the item that
// holds byte 15 is then registered in the output register, from which it can be taken.
// Throughput: one byte item per cycle, set by the byte-wide CRC update, and one result
// per 16 bytes; a stalled result holds only the byte 15 of the next record.
// Reset clears framing to byte 0, the CRC to 0xFFFF and both valid flags.

module record_crc16_validator
   import rcv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_start_record,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_record_valid,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_occupancy_mask,
   output logic [31:0] rsp_entry_count,
   output logic [31:0] rsp_exit_count,
   output logic [15:0] rsp_sequence_res
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_start_ff;
   logic       last;
   logic       out_free;
   logic       advance;
   result_type result;
   result_type rsp_data;

   assign advance   = in_valid_ff && (!last || out_free);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff  <= req_data_byte;
         in_start_ff <= req_start_record;
      end
   end

   rcv_record u_record (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .data_byte    (in_byte_ff),
      .start_record (in_start_ff),
      .last         (last),
      .result       (result)
   );

   rcv_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && last),
      .result    (result),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_record_valid   = rsp_data.record_valid;
   assign rsp_status         = rsp_data.status;
   assign rsp_occupancy_mask = rsp_data.occupancy_mask;
   assign rsp_entry_count    = rsp_data.entry_count;
   assign rsp_exit_count     = rsp_data.exit_count;
   assign rsp_sequence_res   = rsp_data.sequence_res;

endmodule
